// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/sapq_pkg.sv -----
// ----------------------------------------------------------------------------
// sapq_pkg
// Types and codes for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 4;
    localparam int STATUS_W      = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef logic signed [VALUE_W-1:0] value_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } op_t;

endpackage

// ----- src/sapq_if.sv -----
// ----------------------------------------------------------------------------
// sapq_req_if / sapq_rsp_if
// Valid/ready channels carrying command and result words.
// ----------------------------------------------------------------------------
interface sapq_req_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    sapq_pkg::value_t  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sapq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [sapq_pkg::STATUS_W-1:0]    status;
    logic [sapq_pkg::COUNT_W-1:0]     count;
    sapq_pkg::value_t                 top_value;
    logic                             top_valid;

    modport source (output valid, output status, output count, output top_value,
                    output top_valid, input ready);
    modport sink   (input valid, input status, input count, input top_value,
                    input top_valid, output ready);
endinterface

// ----- src/sapq_cell.sv -----
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted row: compares against the broadcast key and
// takes its own, the key, or a neighbour's value.
// ----------------------------------------------------------------------------
module sapq_cell
(
    input  logic              clk,
    input  logic              occ,
    input  sapq_pkg::op_t     op,
    input  sapq_pkg::value_t  key,
    input  sapq_pkg::value_t  left_value,
    input  logic              left_gt,
    input  sapq_pkg::value_t  right_value,
    output sapq_pkg::value_t  value,
    output logic              gt,
    output logic              hit,
    output sapq_pkg::value_t  value_next
);

    sapq_pkg::value_t value_reg;
    logic             boundary;

    // row is descending, so the cells above the key form a prefix
    assign gt       = occ && (value_reg > key);
    assign boundary = !gt && left_gt;
    assign hit      = boundary && occ && (value_reg == key);
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (op.ins_en && !gt)
        begin
            value_next = boundary ? key : left_value;
        end
        else if (op.del_en && !gt)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- src/sorted_array_priority_queue.sv -----
// A result word is registered when its command is taken and is offered in the cycle after.
// Throughput: one command per cycle while each result word is taken; every cell compares and shifts at once.
// The result register frees the input while the previous word is taken.
// Reset (rst_n, async, active low) empties the queue and drops the result;
// slot contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Descending sorted row of DEPTH signed values with insert and delete.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_array_priority_queue
#(
    parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    sapq_req_if.sink         req,
    sapq_rsp_if.source       rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = CNT_W + sapq_pkg::COUNT_W;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          rsp_valid_reg;
    logic [sapq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [sapq_pkg::COUNT_W-1:0]  rsp_count_reg;
    logic                          top_valid_reg;
    sapq_pkg::value_t              top_reg, top_next;

    sapq_pkg::value_t  cell_value [DEPTH];
    sapq_pkg::value_t  cell_next  [DEPTH];
    logic [DEPTH-1:0]  cell_gt;
    logic [DEPTH-1:0]  cell_hit;
    logic [DEPTH-1:0]  cell_occ;
    sapq_pkg::op_t     op;

    logic              accept;
    logic              full;
    logic              empty;
    logic              found;
    logic [EXT_W-1:0]  count_ext;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign found     = |cell_hit;

    assign op.ins_en = accept && (req.cmd == sapq_pkg::CMD_INSERT) && !full;
    assign op.del_en = accept && (req.cmd == sapq_pkg::CMD_DELETE) && found;

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            sapq_pkg::value_t left_v;
            sapq_pkg::value_t right_v;
            logic             left_g;

            assign cell_occ[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign left_v = '0;
                assign left_g = 1'b1;
            end
            else
            begin : g_mid
                assign left_v = cell_value[i-1];
                assign left_g = cell_gt[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_v = '0;
            end
            else
            begin : g_inner
                assign right_v = cell_value[i+1];
            end

            sapq_cell u_cell
            (
                .clk         (clk),
                .occ         (cell_occ[i]),
                .op          (op),
                .key         (req.value),
                .left_value  (left_v),
                .left_gt     (left_g),
                .right_value (right_v),
                .value       (cell_value[i]),
                .gt          (cell_gt[i]),
                .hit         (cell_hit[i]),
                .value_next  (cell_next[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = sapq_pkg::ST_OK;
        if (req.cmd == sapq_pkg::CMD_INSERT)
        begin
            if (full)
                status_next = sapq_pkg::ST_FULL;
            else
                count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            if (empty)
                status_next = sapq_pkg::ST_EMPTY;
            else if (!found)
                status_next = sapq_pkg::ST_NOT_FOUND;
            else
                count_next = count_reg - CNT_W'(1);
        end
        top_next = (count_next == '0) ? '0 : cell_next[0];
    end

    assign count_ext = {{sapq_pkg::COUNT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // count field wraps for deep rows, so top_valid comes from the full count
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            rsp_count_reg <= count_ext[sapq_pkg::COUNT_W-1:0];
            top_valid_reg <= (count_next != '0);
            top_reg       <= top_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.count     = rsp_count_reg;
    assign rsp.top_value = top_reg;
    assign rsp.top_valid = top_valid_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `ASSERT_NEXT(a_accept_gives_word, clk, rst_n, accept, rsp_valid_reg)
    `ASSERT_NEXT(a_insert_grows, clk, rst_n, op.ins_en, count_reg == $past(count_reg) + CNT_W'(1))
    `ASSERT_ALWAYS(a_front_sorted, clk, rst_n, (count_reg < CNT_W'(2)) || (cell_value[0] >= cell_value[1]))

endmodule
